[design/sck_pkg.sv]
// Package for the separable covariance kernel core.
// Holds the queue item type, register indexes and the elaboration-time exp tables.
// No dependencies.
`default_nettype none
package sck_pkg;

   localparam logic [1:0] CSR_MODE  = 2'd0;
   localparam logic [1:0] CSR_INV_X = 2'd1;
   localparam logic [1:0] CSR_INV_Y = 2'd2;

   localparam logic [1:0] MODE_EXP   = 2'd0;
   localparam logic [1:0] MODE_GAUSS = 2'd1;

   localparam logic [23:0] INV_ONE = 24'd65536;
   localparam int WHOLE_LIMIT = 64;

   typedef enum logic [1:0] {
      KIND_EXP,
      KIND_GAUSS,
      KIND_ZERO
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] mag_x;
      logic [31:0] mag_y;
   } item_type;

   typedef logic [31:0] whole_tab_type [WHOLE_LIMIT];

   // Shift and subtract quotient, used only while the tables are elaborated.
   function automatic longint unsigned const_div(input longint unsigned num,
                                                 input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = 64'd0;
      rem = 64'd0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // e^-t for t in [0,1], Q31 in and out, by the alternating series.
   function automatic longint unsigned exp_neg_q31(input longint unsigned t);
      longint unsigned plus;
      longint unsigned minus;
      longint unsigned term;
      plus  = 64'd1 << 31;
      minus = 64'd0;
      term  = 64'd1 << 31;
      for (longint unsigned k = 1; k < 48; k++) begin
         if (term != 0) begin
            term = const_div((term * t) >> 31, k);
            if (k[0]) begin
               minus = minus + term;
            end else begin
               plus = plus + term;
            end
         end
      end
      return (plus > minus) ? plus - minus : 64'd0;
   endfunction

   function automatic logic [31:0] frac_entry(input int unsigned depth,
                                              input int unsigned i);
      longint unsigned t;
      longint unsigned v;
      t = const_div((longint'(i) << 31) + longint'(depth >> 1), longint'(depth));
      v = exp_neg_q31(t);
      return v[31:0];
   endfunction

   function automatic whole_tab_type build_whole();
      whole_tab_type   tab;
      longint unsigned e1;
      longint unsigned prev;
      longint unsigned nxt;
      e1 = exp_neg_q31(64'd1 << 31);
      tab[0] = 32'h8000_0000;
      prev = 64'd1 << 31;
      for (int k = 1; k < WHOLE_LIMIT; k++) begin
         nxt = (prev * e1 + (64'd1 << 30)) >> 31;
         tab[k] = nxt[31:0];
         prev = nxt;
      end
      return tab;
   endfunction

endpackage
`default_nettype wire

[design/sck_front.sv]
// Front end: accepts requests, forms coordinate difference magnitudes and classifies the mode.
// Depends on sck_pkg.
`default_nettype none
module sck_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic signed [31:0] req_first_point_x,
   input  wire logic signed [31:0] req_first_point_y,
   input  wire logic signed [31:0] req_second_point_x,
   input  wire logic signed [31:0] req_second_point_y,
   input  wire logic [1:0]        mode,
   output logic                   push_valid,
   input  wire logic              push_ready,
   output sck_pkg::item_type      push_item
);
   import sck_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   item_type item_in;
   logic signed [32:0] dx;
   logic signed [32:0] dy;

   always_comb begin
      dx = 33'(req_first_point_x) - 33'(req_second_point_x);
      dy = 33'(req_first_point_y) - 33'(req_second_point_y);
      item_in.mag_x = dx[32] ? 32'(-dx) : dx[31:0];
      item_in.mag_y = dy[32] ? 32'(-dy) : dy[31:0];
      case (mode)
         MODE_EXP:   item_in.kind = KIND_EXP;
         MODE_GAUSS: item_in.kind = KIND_GAUSS;
         default:    item_in.kind = KIND_ZERO;
      endcase
      req_ready = !valid_ff || push_ready;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule
`default_nettype wire

[design/sck_queue.sv]
// Short request queue between the front and back ends.
// Depends on sck_pkg.
`default_nettype none
module sck_queue (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push_valid,
   output logic              push_ready,
   input  wire sck_pkg::item_type push_item,
   output logic              pop_valid,
   input  wire logic         pop_ready,
   output sck_pkg::item_type pop_item
);
   import sck_pkg::*;

   localparam int QDEPTH = 4;

   item_type   slot_ff [QDEPTH];
   logic [1:0] wr_ptr_ff;
   logic [1:0] wr_ptr_in;
   logic [1:0] rd_ptr_ff;
   logic [1:0] rd_ptr_in;
   logic [2:0] count_ff;
   logic [2:0] count_in;
   logic       push;
   logic       pop;

   always_comb begin
      push_ready = count_ff != 3'(QDEPTH);
      pop_valid  = count_ff != 3'd0;
      push = push_valid && push_ready;
      pop  = pop_valid && pop_ready;
      wr_ptr_in = push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff + 3'(push) - 3'(pop);
      pop_item  = slot_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(QDEPTH))
      else $error("queue count exceeds depth");
   a_push_only: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 3'd1)
      else $error("queue count did not grow on push");
   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> count_ff == $past(count_ff) - 3'd1)
      else $error("queue count did not shrink on pop");

endmodule
`default_nettype wire

[design/sck_back.sv]
// Back end: scaling, argument formation, table exp with interpolation and rounding.
// Depends on sck_pkg; seven pipeline stages ending in the response register.
`default_nettype none
module sck_back #(
   parameter int EXP_TABLE_DEPTH  = 256,
   parameter int RESULT_FRAC_BITS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         pop_valid,
   output logic              pop_ready,
   input  wire sck_pkg::item_type pop_item,
   input  wire logic [23:0]  inv_x,
   input  wire logic [23:0]  inv_y,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [RESULT_FRAC_BITS:0] rsp_kernel_value
);
   import sck_pkg::*;

   localparam int IDX_W = $clog2(EXP_TABLE_DEPTH + 1);
   localparam int POS_W = 32 + IDX_W;
   localparam int OUT_W = RESULT_FRAC_BITS + 1;
   localparam whole_tab_type WHOLE_TAB = build_whole();

   logic [31:0] frac_tab [EXP_TABLE_DEPTH + 1];

   for (genvar g = 0; g <= EXP_TABLE_DEPTH; g++) begin : g_tab
      localparam logic [31:0] ENTRY = frac_entry(EXP_TABLE_DEPTH, g);
      assign frac_tab[g] = ENTRY;
   end

   logic adv;

   // Stage 1: scaled distances.
   logic        s1_valid_ff;
   kind_type    s1_kind_ff;
   logic [55:0] s1_sx_ff;
   logic [55:0] s1_sy_ff;

   // Stage 2: exponential sum and gaussian squares.
   logic        s2_valid_ff;
   kind_type    s2_kind_ff;
   logic        s2_near_ff;
   logic [56:0] s2_arg_ff;
   logic [53:0] s2_sqx_ff;
   logic [53:0] s2_sqy_ff;
   logic [56:0] s2_arg_in;
   logic [26:0] ax;
   logic [26:0] ay;

   // Stage 3: table position.
   logic             s3_valid_ff;
   logic             s3_zero_ff;
   logic [5:0]       s3_whole_ff;
   logic [IDX_W-1:0] s3_idx_ff;
   logic [30:0]      s3_rem_ff;
   logic [56:0]      arg;
   logic [54:0]      gsum;
   logic [POS_W-1:0] pos;
   logic             s3_zero_in;

   // Stage 4: table reads.
   logic        s4_valid_ff;
   logic        s4_zero_ff;
   logic [5:0]  s4_whole_ff;
   logic [31:0] s4_lo_ff;
   logic [31:0] s4_diff_ff;
   logic [30:0] s4_rem_ff;
   logic [IDX_W-1:0] idx_hi;

   // Stage 5: interpolation product.
   logic        s5_valid_ff;
   logic        s5_zero_ff;
   logic [5:0]  s5_whole_ff;
   logic [31:0] s5_lo_ff;
   logic [31:0] s5_step_ff;
   logic [62:0] interp;

   // Stage 6: whole-part scaling.
   logic        s6_valid_ff;
   logic        s6_zero_ff;
   logic [31:0] s6_r_ff;
   logic [31:0] v;
   logic [63:0] prod;

   // Response register.
   logic             rsp_valid_ff;
   logic [OUT_W-1:0] rsp_value_ff;
   logic [OUT_W-1:0] rsp_value_in;
   logic [32:0]      rnd;

   always_comb begin
      adv = !rsp_valid_ff || rsp_ready;
      pop_ready = adv;

      ax = s1_sx_ff[34:8];
      ay = s1_sy_ff[34:8];
      s2_arg_in = 57'(s1_sx_ff) + 57'(s1_sy_ff);

      gsum = 55'(s2_sqx_ff) + 55'(s2_sqy_ff) + 55'(16'h8000);
      arg = '0;
      s3_zero_in = 1'b1;
      case (s2_kind_ff)
         KIND_EXP: begin
            arg = s2_arg_ff;
            s3_zero_in = 1'b0;
         end
         KIND_GAUSS: begin
            arg = 57'(gsum[54:16]);
            s3_zero_in = !s2_near_ff;
         end
         default: begin
            arg = '0;
            s3_zero_in = 1'b1;
         end
      endcase
      if (arg[56:38] != '0) begin
         s3_zero_in = 1'b1;
      end
      pos = POS_W'(arg[31:0]) * POS_W'(EXP_TABLE_DEPTH);

      idx_hi = s3_idx_ff + IDX_W'(1);
      interp = 63'(s4_diff_ff) * 63'(s4_rem_ff);

      v = s5_lo_ff - s5_step_ff;
      prod = 64'(WHOLE_TAB[s5_whole_ff]) * 64'(v);

      rnd = 33'(s6_r_ff) + (33'd1 << (30 - RESULT_FRAC_BITS));
      rsp_value_in = s6_zero_ff ? '0 : OUT_W'(rnd >> (31 - RESULT_FRAC_BITS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= pop_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         rsp_valid_ff <= s6_valid_ff;
      end
      if (adv) begin
         s1_kind_ff <= pop_item.kind;
         s1_sx_ff   <= 56'(pop_item.mag_x) * 56'(inv_x);
         s1_sy_ff   <= 56'(pop_item.mag_y) * 56'(inv_y);

         s2_kind_ff <= s1_kind_ff;
         s2_near_ff <= (s1_sx_ff[55:35] == '0) && (s1_sy_ff[55:35] == '0);
         s2_arg_ff  <= s2_arg_in;
         s2_sqx_ff  <= 54'(ax) * 54'(ax);
         s2_sqy_ff  <= 54'(ay) * 54'(ay);

         s3_zero_ff  <= s3_zero_in;
         s3_whole_ff <= arg[37:32];
         s3_idx_ff   <= pos[POS_W-1:32];
         s3_rem_ff   <= pos[31:1];

         s4_zero_ff  <= s3_zero_ff;
         s4_whole_ff <= s3_whole_ff;
         s4_lo_ff    <= frac_tab[s3_idx_ff];
         s4_diff_ff  <= frac_tab[s3_idx_ff] - frac_tab[idx_hi];
         s4_rem_ff   <= s3_rem_ff;

         s5_zero_ff  <= s4_zero_ff;
         s5_whole_ff <= s4_whole_ff;
         s5_lo_ff    <= s4_lo_ff;
         s5_step_ff  <= interp[62:31];

         s6_zero_ff <= s5_zero_ff;
         s6_r_ff    <= prod[62:31];

         rsp_value_ff <= rsp_value_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kernel_value = rsp_value_ff;

endmodule
`default_nettype wire

[design/separable_covariance_kernel_eval_core.sv]
// Separable covariance kernel core: top level with configuration registers.
// Throughput: one request per cycle while rsp_ready is held high, set by the fully pipelined back end.
// The four-entry queue lets the front end keep taking requests during short stalls.
// Reset is synchronous and active high; it clears handshake state and sets mode 0,
// inverse lengths 1.0 and 10.0.
`default_nettype none
module separable_covariance_kernel_eval_core #(
   parameter int EXP_TABLE_DEPTH  = 256,
   parameter int RESULT_FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [1:0]         csr_index,
   input  wire logic [23:0]        csr_wdata,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [31:0] req_first_point_x,
   input  wire logic signed [31:0] req_first_point_y,
   input  wire logic signed [31:0] req_second_point_x,
   input  wire logic signed [31:0] req_second_point_y,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [RESULT_FRAC_BITS:0] rsp_kernel_value
);
   import sck_pkg::*;

   logic [1:0]  mode_ff;
   logic [1:0]  mode_in;
   logic [23:0] inv_x_ff;
   logic [23:0] inv_x_in;
   logic [23:0] inv_y_ff;
   logic [23:0] inv_y_in;
   logic [23:0] inv_x_eff;
   logic [23:0] inv_y_eff;

   logic     push_valid;
   logic     push_ready;
   item_type push_item;
   logic     pop_valid;
   logic     pop_ready;
   item_type pop_item;

   always_comb begin
      mode_in  = mode_ff;
      inv_x_in = inv_x_ff;
      inv_y_in = inv_y_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MODE:  mode_in  = csr_wdata[1:0];
            CSR_INV_X: inv_x_in = csr_wdata;
            CSR_INV_Y: inv_y_in = csr_wdata;
            default:   mode_in  = mode_ff;
         endcase
      end
      inv_x_eff = (inv_x_ff == '0) ? INV_ONE : inv_x_ff;
      inv_y_eff = (inv_y_ff == '0) ? INV_ONE : inv_y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_EXP;
         inv_x_ff <= 24'd65536;
         inv_y_ff <= 24'd655360;
      end else begin
         mode_ff  <= mode_in;
         inv_x_ff <= inv_x_in;
         inv_y_ff <= inv_y_in;
      end
   end

   sck_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_first_point_x  (req_first_point_x),
      .req_first_point_y  (req_first_point_y),
      .req_second_point_x (req_second_point_x),
      .req_second_point_y (req_second_point_y),
      .mode               (mode_ff),
      .push_valid         (push_valid),
      .push_ready         (push_ready),
      .push_item          (push_item)
   );

   sck_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   sck_back #(
      .EXP_TABLE_DEPTH  (EXP_TABLE_DEPTH),
      .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_item         (pop_item),
      .inv_x            (inv_x_eff),
      .inv_y            (inv_y_eff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kernel_value (rsp_kernel_value)
   );

endmodule
`default_nettype wire
